[rtl/core/smvs_pkg.sv]
package smvs_pkg;

    // Store geometry.
    localparam int TOTAL_WORDS = 4096;
    localparam int MAX_VECTORS = 16;
    localparam int ADDR_W      = $clog2(TOTAL_WORDS);
    localparam int VID_W       = 4;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int VC_W        = 5;
    localparam int WORD_W      = 32;
    localparam int PROD_W      = VID_W + CNT_W;

    // Action codes.
    typedef enum logic [2:0] {
        ACT_PUSH      = 3'd0,
        ACT_READ      = 3'd1,
        ACT_WRITE     = 3'd2,
        ACT_CLEAR     = 3'd3,
        ACT_CLEAR_ALL = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]        action;
        logic [VID_W-1:0]  vector_id;
        logic [IDX_W-1:0]  elem_index;
        logic [WORD_W-1:0] word_in;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] read_word;
        logic [CNT_W-1:0]  fill_count;
        logic [CNT_W-1:0]  seg_capacity;
    } t_out_item;

    // Segment size for each value of the vector count register. Zero marks a
    // setting that disables the block.
    localparam logic [CNT_W-1:0] SEG_SIZE_TABLE [32] = '{
        CNT_W'(0),
        CNT_W'(TOTAL_WORDS / 1),  CNT_W'(TOTAL_WORDS / 2),
        CNT_W'(TOTAL_WORDS / 3),  CNT_W'(TOTAL_WORDS / 4),
        CNT_W'(TOTAL_WORDS / 5),  CNT_W'(TOTAL_WORDS / 6),
        CNT_W'(TOTAL_WORDS / 7),  CNT_W'(TOTAL_WORDS / 8),
        CNT_W'(TOTAL_WORDS / 9),  CNT_W'(TOTAL_WORDS / 10),
        CNT_W'(TOTAL_WORDS / 11), CNT_W'(TOTAL_WORDS / 12),
        CNT_W'(TOTAL_WORDS / 13), CNT_W'(TOTAL_WORDS / 14),
        CNT_W'(TOTAL_WORDS / 15), CNT_W'(TOTAL_WORDS / 16),
        CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0),
        CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0),
        CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0)
    };

endpackage

[rtl/core/smvs_ram.sv]
module smvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/segmented_multi_vector_store.sv]
// An accepted item passes through stage one and then stage two before its result is offered.
// Throughput: one item per cycle; the input register, the count update and
// the word store port each handle one item per cycle, so the input stalls only
// when the receiver holds back a result and both stages are occupied.
// Reset (synchronous, active low) empties the pipeline, zeroes every fill count
// and sets the vector count to one; the word store itself is not cleared.
module segmented_multi_vector_store
    import smvs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_item,
    input  logic            i_cfg_wr_en,
    input  logic [VC_W-1:0] i_cfg_wr_data
);

    // Configuration: the vector count and the segment size derived from it.
    // A segment size of zero means the block is disabled.
    logic [VC_W-1:0]  r_vec_count;
    logic [CNT_W-1:0] r_seg_size;

    // Stage one holds the accepted item; stage two holds the result fields
    // while the word store delivers the read data alongside.
    logic             r_s1_valid;
    t_in_item         r_s1;
    logic             r_s2_valid;
    logic             r_s2_ok;
    logic             r_s2_rd;
    logic [CNT_W-1:0] r_s2_count;
    logic [CNT_W-1:0] r_s2_cap;

    // One fill count per vector.
    logic [CNT_W-1:0] r_fill [MAX_VECTORS];
    logic [CNT_W-1:0] n_fill [MAX_VECTORS];

    logic              s2_free;
    logic              s1_move;
    logic              enabled;
    logic              id_ok;
    logic              idx_ok;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  new_cnt;
    logic [CNT_W-1:0]  offset;
    logic [PROD_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic              res_ok;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    // Stage two can take a new result when it is empty or its result leaves.
    assign s2_free    = !r_s2_valid || i_out_ready;
    assign s1_move    = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s2_free;

    assign enabled = (r_seg_size != '0);
    assign id_ok   = enabled && ({1'b0, r_s1.vector_id} < r_vec_count);
    assign idx_ok  = ({1'b0, r_s1.elem_index} < r_seg_size);
    assign cur_cnt = r_fill[r_s1.vector_id];

    // Word address of an element: segment base plus offset. A push uses the
    // fill count as its offset, every other action the element index.
    assign offset = (r_s1.action == ACT_PUSH) ? cur_cnt : {1'b0, r_s1.elem_index};
    assign base   = PROD_W'(r_s1.vector_id) * PROD_W'(r_seg_size);
    assign addr   = ADDR_W'(base + PROD_W'(offset));

    always_comb begin
        n_fill  = r_fill;
        new_cnt = cur_cnt;
        res_ok  = 1'b0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        unique case (r_s1.action)
            ACT_PUSH: begin
                if (id_ok && (cur_cnt < r_seg_size)) begin
                    res_ok  = 1'b1;
                    ram_we  = 1'b1;
                    new_cnt = cur_cnt + CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (id_ok && idx_ok) begin
                    res_ok = 1'b1;
                    ram_re = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (id_ok && idx_ok) begin
                    res_ok = 1'b1;
                    ram_we = 1'b1;
                    // Writing past the end stretches the vector up to the index.
                    if ({1'b0, r_s1.elem_index} >= cur_cnt) begin
                        new_cnt = {1'b0, r_s1.elem_index} + CNT_W'(1);
                    end
                end
            end
            ACT_CLEAR: begin
                if (id_ok) begin
                    res_ok  = 1'b1;
                    new_cnt = '0;
                end
            end
            ACT_CLEAR_ALL: begin
                if (enabled) begin
                    res_ok = 1'b1;
                    for (int v = 0; v < MAX_VECTORS; v++) begin
                        if (VC_W'(v) < r_vec_count) begin
                            n_fill[v] = '0;
                        end
                    end
                    // The targeted vector, when valid, is among those cleared.
                    new_cnt = '0;
                end
            end
            default: begin
                // Unknown actions leave the state alone and report failure.
            end
        endcase
        if (r_s1.action != ACT_CLEAR_ALL) begin
            n_fill[r_s1.vector_id] = new_cnt;
        end
    end

    // Control registers and fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_count <= VC_W'(1);
            r_seg_size  <= SEG_SIZE_TABLE[1];
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            for (int v = 0; v < MAX_VECTORS; v++) begin
                r_fill[v] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_vec_count <= i_cfg_wr_data;
                r_seg_size  <= SEG_SIZE_TABLE[i_cfg_wr_data];
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_fill <= n_fill;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_item;
        end
        if (s1_move) begin
            r_s2_ok    <= res_ok;
            r_s2_rd    <= ram_re;
            r_s2_count <= id_ok ? new_cnt : '0;
            r_s2_cap   <= id_ok ? r_seg_size : '0;
        end
    end

    // The word store reads only when an item moves on, so its output holds
    // steady while a result waits at the output.
    smvs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move && ram_we),
        .i_waddr (addr),
        .i_wdata (r_s1.word_in),
        .i_re    (s1_move && ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid             = r_s2_valid;
    assign o_out_item.ok           = r_s2_ok;
    assign o_out_item.read_word    = r_s2_rd ? ram_rdata : '0;
    assign o_out_item.fill_count   = r_s2_count;
    assign o_out_item.seg_capacity = r_s2_cap;

endmodule

[rtl/core/smvs_checker.sv]
module smvs_checker
    import smvs_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input t_out_item       o_out_item
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its fields.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // An invalid target reports neither capacity nor count.
    a_zero_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.seg_capacity == '0) |-> (o_out_item.fill_count == '0))
        else $error("count reported without capacity");

    // Read data only comes with a successful read.
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.read_word != '0) |-> o_out_item.ok)
        else $error("read data on a failed item");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

endmodule

bind segmented_multi_vector_store smvs_checker u_smvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_item    (o_out_item)
);
